// ===== src/matrix_inverse_3x3_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MI3_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent, delayed by the n argument.
`define MI3_ASSERT_DELAY(lbl, clk, rst, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== src/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse package
// Widths and payload types shared by all modules, and the saturation helper.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned ELEM_WIDTH   = 32;
  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned THR_WIDTH    = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 31'd17;

  localparam int unsigned LANES        = 9;
  localparam int unsigned PROD_WIDTH   = 2 * ELEM_WIDTH;
  localparam int unsigned COF_WIDTH    = PROD_WIDTH + 1;
  localparam int unsigned DET_WIDTH    = 3 * ELEM_WIDTH + 3;
  localparam int unsigned DMAG_WIDTH   = DET_WIDTH - 1;
  localparam int unsigned QUO_WIDTH    = ELEM_WIDTH;

  localparam int unsigned FRONT_STAGES = 8;
  localparam int unsigned LANE_LAT     = QUO_WIDTH + 3;
  localparam int unsigned TOTAL_LAT    = FRONT_STAGES + LANE_LAT + 1;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic [DMAG_WIDTH-1:0]        dmag_t;

  typedef struct packed {
    elem_t a00;
    elem_t a01;
    elem_t a02;
    elem_t a10;
    elem_t a11;
    elem_t a12;
    elem_t a20;
    elem_t a21;
    elem_t a22;
  } in_t;

  typedef struct packed {
    elem_t inv00;
    elem_t inv01;
    elem_t inv02;
    elem_t inv10;
    elem_t inv11;
    elem_t inv12;
    elem_t inv20;
    elem_t inv21;
    elem_t inv22;
    elem_t det_value;
    logic  singular;
  } out_t;

  // Cofactor magnitude and the sign of the quotient it produces.
  typedef struct packed {
    logic                  neg;
    logic [PROD_WIDTH-1:0] mag;
  } lane_in_t;

  // Per-matrix information that bypasses the division lanes.
  typedef struct packed {
    logic  valid;
    logic  singular;
    elem_t det_value;
  } side_t;

  // Clamp a magnitude to the signed element range and apply the sign.
  function automatic elem_t sat_elem(input logic [ELEM_WIDTH:0] mag, input logic neg);
    logic [ELEM_WIDTH:0] lim;
    logic [ELEM_WIDTH:0] m;
    logic [ELEM_WIDTH:0] r;
    lim = {2'b01, {(ELEM_WIDTH-1){1'b0}}} - {{ELEM_WIDTH{1'b0}}, ~neg};
    m   = (mag > lim) ? lim : mag;
    r   = neg ? (~m + 1'b1) : m;
    return r[ELEM_WIDTH-1:0];
  endfunction

endpackage

// ===== src/mi3_front.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse front end
// Cofactors, exact determinant, singular test and rounded determinant output.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int unsigned FracBits = mi3_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  mi3_pkg::in_t                   matrix_i,
  input  logic [mi3_pkg::THR_WIDTH-1:0]  thr_i,
  output mi3_pkg::side_t                 side_o,
  output mi3_pkg::dmag_t                 den_o,
  output mi3_pkg::lane_in_t              cof_o [mi3_pkg::LANES]
);

  localparam int unsigned W   = mi3_pkg::ELEM_WIDTH;
  localparam int unsigned PW  = mi3_pkg::PROD_WIDTH;
  localparam int unsigned CW  = mi3_pkg::COF_WIDTH;
  localparam int unsigned DW  = mi3_pkg::DET_WIDTH;
  localparam int unsigned DAW = mi3_pkg::DMAG_WIDTH;
  localparam int unsigned NL  = mi3_pkg::LANES;
  localparam int unsigned NS  = mi3_pkg::FRONT_STAGES;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cofw_t;
  typedef logic signed [PW:0]   pp_t;
  typedef logic signed [DW-1:0] det_t;

  function automatic prod_t smul(input mi3_pkg::elem_t x, input mi3_pkg::elem_t y);
    return prod_t'(x) * prod_t'(y);
  endfunction

  logic [NS-1:0] vld_q;

  prod_t                 p1_q [NL][2];
  mi3_pkg::elem_t        r1_q [3];
  cofw_t                 c2_q [NL];
  mi3_pkg::elem_t        r2_q [3];
  pp_t                   m3lo_q [3];
  pp_t                   m3hi_q [3];
  cofw_t                 c3_q [NL];
  det_t                  t4_q [3];
  cofw_t                 c4_q [NL];
  det_t                  det5_q;
  cofw_t                 c5_q [NL];
  logic [DAW-1:0]        dabs6_q;
  logic                  dneg6_q;
  mi3_pkg::lane_in_t     cof6_q [NL];
  logic                  sing7_q;
  logic [DAW:0]          rnd7_q;
  logic                  dneg7_q;
  logic [DAW-1:0]        dabs7_q;
  mi3_pkg::lane_in_t     cof7_q [NL];
  mi3_pkg::elem_t        det8_q;
  logic                  sing8_q;
  logic [DAW-1:0]        dabs8_q;
  mi3_pkg::lane_in_t     cof8_q [NL];

  det_t                  dfull;
  logic                  dneg;
  cofw_t                 cfull [NL];
  logic [DAW-1:0]        thr_sh;
  logic [DAW:0]          half;
  logic [DAW:0]          sh8;
  logic                  big8;
  logic [W:0]            m8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // Stage 1: the eighteen 2x2 minor products.
  always_ff @(posedge clk_i) begin
    p1_q[0][0] <= smul(matrix_i.a11, matrix_i.a22);
    p1_q[0][1] <= smul(matrix_i.a12, matrix_i.a21);
    p1_q[1][0] <= smul(matrix_i.a02, matrix_i.a21);
    p1_q[1][1] <= smul(matrix_i.a01, matrix_i.a22);
    p1_q[2][0] <= smul(matrix_i.a01, matrix_i.a12);
    p1_q[2][1] <= smul(matrix_i.a02, matrix_i.a11);
    p1_q[3][0] <= smul(matrix_i.a12, matrix_i.a20);
    p1_q[3][1] <= smul(matrix_i.a10, matrix_i.a22);
    p1_q[4][0] <= smul(matrix_i.a00, matrix_i.a22);
    p1_q[4][1] <= smul(matrix_i.a02, matrix_i.a20);
    p1_q[5][0] <= smul(matrix_i.a02, matrix_i.a10);
    p1_q[5][1] <= smul(matrix_i.a00, matrix_i.a12);
    p1_q[6][0] <= smul(matrix_i.a10, matrix_i.a21);
    p1_q[6][1] <= smul(matrix_i.a11, matrix_i.a20);
    p1_q[7][0] <= smul(matrix_i.a01, matrix_i.a20);
    p1_q[7][1] <= smul(matrix_i.a00, matrix_i.a21);
    p1_q[8][0] <= smul(matrix_i.a00, matrix_i.a11);
    p1_q[8][1] <= smul(matrix_i.a01, matrix_i.a10);
    r1_q[0]    <= matrix_i.a00;
    r1_q[1]    <= matrix_i.a01;
    r1_q[2]    <= matrix_i.a02;
  end

  // Stages 2 to 5: cofactors, then the expansion along row 0. The cofactor is
  // split into an unsigned low word and a signed high word so that no
  // multiplier is wider than one element by one element plus a bit.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NL; k++) begin
      c2_q[k] <= cofw_t'(p1_q[k][0]) - cofw_t'(p1_q[k][1]);
    end
    r2_q <= r1_q;

    for (int j = 0; j < 3; j++) begin
      m3lo_q[j] <= pp_t'(r2_q[j]) * pp_t'($signed({1'b0, c2_q[3*j][W-1:0]}));
      m3hi_q[j] <= pp_t'(r2_q[j]) * pp_t'($signed(c2_q[3*j][CW-1:W]));
    end
    c3_q <= c2_q;

    for (int j = 0; j < 3; j++) begin
      t4_q[j] <= (det_t'(m3hi_q[j]) <<< W) + det_t'(m3lo_q[j]);
    end
    c4_q <= c3_q;

    det5_q <= t4_q[0] + t4_q[1] + t4_q[2];
    c5_q   <= c4_q;
  end

  always_comb begin
    dneg  = det5_q[DW-1];
    dfull = dneg ? -det5_q : det5_q;
    for (int k = 0; k < NL; k++) begin
      cfull[k] = c5_q[k][CW-1] ? -c5_q[k] : c5_q[k];
    end
    thr_sh = DAW'(thr_i) << (2 * FracBits);
    half   = {{DAW{1'b0}}, 1'b1} << (2 * FracBits - 1);
    sh8    = rnd7_q >> (2 * FracBits);
    big8   = |sh8[DAW:W+1];
    m8     = big8 ? {1'b1, {W{1'b0}}} : sh8[W:0];
  end

  // Stages 6 to 8: magnitudes, singular test, determinant rounding.
  always_ff @(posedge clk_i) begin
    dabs6_q <= dfull[DAW-1:0];
    dneg6_q <= dneg;
    for (int k = 0; k < NL; k++) begin
      cof6_q[k].mag <= cfull[k][PW-1:0];
      cof6_q[k].neg <= c5_q[k][CW-1] ^ dneg;
    end

    sing7_q <= (dabs6_q == '0) || (dabs6_q < thr_sh);
    rnd7_q  <= {1'b0, dabs6_q} + half;
    dneg7_q <= dneg6_q;
    dabs7_q <= dabs6_q;
    cof7_q  <= cof6_q;

    det8_q  <= mi3_pkg::sat_elem(m8, dneg7_q);
    sing8_q <= sing7_q;
    dabs8_q <= dabs7_q;
    cof8_q  <= cof7_q;
  end

  assign side_o.valid     = vld_q[NS-1];
  assign side_o.singular  = sing8_q;
  assign side_o.det_value = det8_q;
  assign den_o            = dabs8_q;
  assign cof_o            = cof8_q;

endmodule

// ===== src/mi3_lane.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse division lane
// Pipelined restoring division of one scaled cofactor by the determinant.
// ----------------------------------------------------------------------------
module mi3_lane #(
  parameter int unsigned FracBits = mi3_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  mi3_pkg::lane_in_t cof_i,
  input  mi3_pkg::dmag_t    den_i [mi3_pkg::QUO_WIDTH+2],
  output mi3_pkg::elem_t    quo_o
);

  localparam int unsigned K    = mi3_pkg::QUO_WIDTH;
  localparam int unsigned DAW  = mi3_pkg::DMAG_WIDTH;
  localparam int unsigned NW   = mi3_pkg::PROD_WIDTH + 2 * FracBits;
  localparam int unsigned CMPW = DAW + K;

  logic [NW-1:0]  num;
  logic           ovf0;

  logic [DAW-1:0] rem_q [K+1];
  logic [K-1:0]   nlo_q [K+1];
  logic [K-1:0]   quo_q [K+1];
  logic           ovf_q [K+1];
  logic           neg_q [K+1];

  logic           rup_q;
  logic [K-1:0]   q1_q;
  logic           ovf1_q;
  logic           neg1_q;
  logic [K:0]     mag2;
  mi3_pkg::elem_t res_q;

  // The quotient has only K bits to fill; anything at or above 2^K saturates.
  always_comb begin
    num  = {cof_i.mag, {(2 * FracBits){1'b0}}};
    ovf0 = CMPW'(num) >= {den_i[0], {K{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= DAW'(num[NW-1:K]);
    nlo_q[0] <= num[K-1:0];
    quo_q[0] <= '0;
    ovf_q[0] <= ovf0;
    neg_q[0] <= cof_i.neg;
  end

  for (genvar j = 1; j <= K; j++) begin : g_step
    logic [DAW:0] trial;
    logic [DAW:0] dext;
    logic [DAW:0] diff;
    logic         ge;

    always_comb begin
      trial = {rem_q[j-1], nlo_q[j-1][K-1]};
      dext  = {1'b0, den_i[j]};
      diff  = trial - dext;
      ge    = trial >= dext;
    end

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? diff[DAW-1:0] : trial[DAW-1:0];
      nlo_q[j] <= {nlo_q[j-1][K-2:0], 1'b0};
      quo_q[j] <= {quo_q[j-1][K-2:0], ge};
      ovf_q[j] <= ovf_q[j-1];
      neg_q[j] <= neg_q[j-1];
    end
  end

  // Round half away from zero on the magnitude, then saturate and sign.
  always_comb begin
    mag2 = ovf1_q ? {1'b1, {K{1'b0}}} : ({1'b0, q1_q} + {{K{1'b0}}, rup_q});
  end

  always_ff @(posedge clk_i) begin
    rup_q  <= {rem_q[K], 1'b0} >= {1'b0, den_i[K+1]};
    q1_q   <= quo_q[K];
    ovf1_q <= ovf_q[K];
    neg1_q <= neg_q[K];
    res_q  <= mi3_pkg::sat_elem(mag2, neg1_q);
  end

  assign quo_o = res_q;

endmodule

// ===== src/mi3_merge.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse merge stage
// Aligns the determinant and singular flag with the lane quotients.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mi3_pkg::side_t side_i,
  input  mi3_pkg::elem_t quo_i [mi3_pkg::LANES],
  output logic           result_valid_o,
  output mi3_pkg::out_t  result_o
);

  localparam int unsigned L = mi3_pkg::LANE_LAT;

  logic [L-1:0]   vld_q;
  logic           sing_q [L];
  mi3_pkg::elem_t det_q [L];
  logic           sing;
  logic           out_vld_q;
  mi3_pkg::out_t  out_d;
  mi3_pkg::out_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[L-2:0], side_i.valid};
      out_vld_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q[0] <= side_i.singular;
    det_q[0]  <= side_i.det_value;
    for (int i = 1; i < L; i++) begin
      sing_q[i] <= sing_q[i-1];
      det_q[i]  <= det_q[i-1];
    end
    out_q <= out_d;
  end

  // A singular matrix reports a zero inverse but keeps its determinant.
  always_comb begin
    sing            = sing_q[L-1];
    out_d.inv00     = sing ? '0 : quo_i[0];
    out_d.inv01     = sing ? '0 : quo_i[1];
    out_d.inv02     = sing ? '0 : quo_i[2];
    out_d.inv10     = sing ? '0 : quo_i[3];
    out_d.inv11     = sing ? '0 : quo_i[4];
    out_d.inv12     = sing ? '0 : quo_i[5];
    out_d.inv20     = sing ? '0 : quo_i[6];
    out_d.inv21     = sing ? '0 : quo_i[7];
    out_d.inv22     = sing ? '0 : quo_i[8];
    out_d.det_value = det_q[L-1];
    out_d.singular  = sing;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

// ===== src/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// 3x3 matrix inverse by adjugate over determinant, signed fixed point
// Pipeline: eight cofactor and determinant stages, one division stage per
//   quotient bit in nine parallel lanes, rounding, merge register.
// Throughput: one matrix per clock; busy is high only in reset and in the
//   cycle after reset is released.
// Reset clears the pipeline valids and loads the singular threshold with 17.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int unsigned FracBits = mi3_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mi3_pkg::in_t                  matrix_i,
  input  logic                          cfg_we_i,
  input  logic [mi3_pkg::THR_WIDTH-1:0] cfg_wdata_i,
  output logic                          result_valid_o,
  output mi3_pkg::out_t                 result_o
);

  localparam int unsigned K  = mi3_pkg::QUO_WIDTH;
  localparam int unsigned NL = mi3_pkg::LANES;

  logic                          busy_q;
  logic [mi3_pkg::THR_WIDTH-1:0] thr_q;
  logic                          accept;
  mi3_pkg::side_t                side;
  mi3_pkg::dmag_t                den;
  mi3_pkg::lane_in_t             cof [NL];
  mi3_pkg::dmag_t                dp_q [K+1];
  mi3_pkg::dmag_t                den_arr [K+2];
  mi3_pkg::elem_t                quo [NL];

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      thr_q  <= mi3_pkg::THR_RESET;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  mi3_front #(.FracBits(FracBits)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .matrix_i (matrix_i),
    .thr_i    (thr_q),
    .side_o   (side),
    .den_o    (den),
    .cof_o    (cof)
  );

  // The determinant travels once beside the lanes; each division step taps it.
  always_ff @(posedge clk_i) begin
    dp_q[0] <= den;
    for (int j = 1; j <= K; j++) begin
      dp_q[j] <= dp_q[j-1];
    end
  end

  always_comb begin
    den_arr[0] = den;
    for (int j = 0; j <= K; j++) begin
      den_arr[j+1] = dp_q[j];
    end
  end

  for (genvar i = 0; i < NL; i++) begin : g_lane
    mi3_lane #(.FracBits(FracBits)) u_lane (
      .clk_i (clk_i),
      .cof_i (cof[i]),
      .den_i (den_arr),
      .quo_o (quo[i])
    );
  end

  mi3_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .side_i         (side),
    .quo_i          (quo),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== src/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse port checker
// Watches transaction timing and the singular result on the top-level ports.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_macros.svh"

module mi3_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input mi3_pkg::out_t result_o
);

  localparam int unsigned LAT = mi3_pkg::TOTAL_LAT;

  `MI3_ASSERT_DELAY(a_result_follows, clk_i, rst_ni, start && !busy, LAT, result_valid_o, "accepted transaction produced no result")
  `MI3_ASSERT_IMPL(a_result_has_cause, clk_i, rst_ni, result_valid_o, $past(start && !busy, LAT), "result without an accepted transaction")
  `MI3_ASSERT_IMPL(a_singular_zero, clk_i, rst_ni, result_valid_o && result_o.singular, (result_o.inv00 == '0) && (result_o.inv01 == '0) && (result_o.inv02 == '0) && (result_o.inv10 == '0) && (result_o.inv11 == '0) && (result_o.inv12 == '0) && (result_o.inv20 == '0) && (result_o.inv21 == '0) && (result_o.inv22 == '0), "singular result with nonzero inverse")

endmodule

bind matrix_inverse_3x3 mi3_checker u_checker (.*);

// ===== tb/inverse_checker.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse checker
// Watches the matrix and threshold inputs and the result port of the 3x3
// inverse. It works out each expected inverse in wide exact arithmetic and
// compares every result transaction with the oldest one, field by field.
// ----------------------------------------------------------------------------
module inverse_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  mi3_pkg::in_t                  matrix_i,
  input  logic                          cfg_we_i,
  input  logic [mi3_pkg::THR_WIDTH-1:0] cfg_wdata_i,
  input  logic                          result_valid_i,
  input  mi3_pkg::out_t                 result_i,
  output int                            pending_o,
  output int                            errors_o,
  output int                            results_o,
  output int                            singular_o
);

  typedef logic signed [255:0] wide_t;

  localparam int unsigned FIELDS = 10;
  localparam int unsigned OUT_W = $bits(mi3_pkg::out_t);

  mi3_pkg::out_t expected_inverses[$];
  logic [mi3_pkg::THR_WIDTH-1:0] threshold;
  string field_name[FIELDS] = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
                                "inv20", "inv21", "inv22", "det_value"};

  // Quotient rounded to nearest with ties away from zero, then clamped.
  function automatic mi3_pkg::elem_t div_round_sat(wide_t num, wide_t den);
    logic [255:0] n;
    logic [255:0] d;
    wide_t q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = wide_t'((2 * n + d) / (2 * d));
    if ((num < 0) != (den < 0)) q = -q;
    if (q > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (q < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return mi3_pkg::elem_t'(q);
  endfunction

  function automatic mi3_pkg::out_t invert_exact(mi3_pkg::in_t m,
                                                 logic [mi3_pkg::THR_WIDTH-1:0] thr);
    wide_t a[9];
    wide_t cof[9];
    wide_t det;
    wide_t mag;
    wide_t limit;
    mi3_pkg::out_t r;
    logic sing;
    a = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    mag = (det < 0) ? -det : det;
    limit = wide_t'({1'b0, thr}) <<< (2 * mi3_pkg::FRAC_BITS);
    sing = (det == 0) || (mag < limit);
    r = '0;
    for (int i = 0; i < 9; i++) begin
      if (!sing) begin
        r[OUT_W-1-32*i -: 32] = div_round_sat(cof[i] <<< (2 * mi3_pkg::FRAC_BITS), det);
      end
    end
    r.det_value = div_round_sat(det, wide_t'(1) <<< (2 * mi3_pkg::FRAC_BITS));
    r.singular = sing;
    return r;
  endfunction

  initial begin
    errors_o = 0;
    results_o = 0;
    singular_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mi3_pkg::out_t want;
    if (!rst_ni) begin
      threshold = mi3_pkg::THR_RESET;
    end else begin
      if (start_i && !busy_i) expected_inverses.push_back(invert_exact(matrix_i, threshold));
      if (result_valid_i) begin
        results_o++;
        if (expected_inverses.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result transaction %h", $time, result_i);
        end else begin
          want = expected_inverses.pop_front();
          if (want.singular) singular_o++;
          for (int k = 0; k < FIELDS; k++) begin
            if (want[OUT_W-1-32*k -: 32] !== result_i[OUT_W-1-32*k -: 32]) begin
              errors_o++;
              $display("%0t: %s expected %h actual %h", $time, field_name[k],
                       want[OUT_W-1-32*k -: 32], result_i[OUT_W-1-32*k -: 32]);
            end
          end
          if (want.singular !== result_i.singular) begin
            errors_o++;
            $display("%0t: singular expected %b actual %b", $time, want.singular,
                     result_i.singular);
          end
        end
      end
      if (cfg_we_i) threshold = cfg_wdata_i;
    end
    pending_o = expected_inverses.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Matrix inverse testbench
// Drives directed and random 3x3 matrices into the inverse under three pacing
// phases and several singular thresholds; the checker grades every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam mi3_pkg::elem_t ONE = 32'sh01000000;
  localparam mi3_pkg::elem_t EMAX = 32'sh7fffffff;
  localparam mi3_pkg::elem_t EMIN = 32'sh80000000;
  localparam int unsigned DRAIN = mi3_pkg::TOTAL_LAT + 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  mi3_pkg::in_t matrix = '0;
  logic cfg_we = 1'b0;
  logic [mi3_pkg::THR_WIDTH-1:0] cfg_wdata = '0;
  logic result_valid;
  mi3_pkg::out_t result;
  int pending;
  int errors;
  int results;
  int singulars;
  int items = 0;

  matrix_inverse_3x3 DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .matrix_i(matrix),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .result_valid_o(result_valid),
    .result_o(result)
  );

  inverse_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .matrix_i(matrix),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .result_valid_i(result_valid),
    .result_i(result), .pending_o(pending), .errors_o(errors), .results_o(results),
    .singular_o(singulars)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

  function automatic mi3_pkg::in_t diag(mi3_pkg::elem_t x, mi3_pkg::elem_t y,
                                        mi3_pkg::elem_t z);
    mi3_pkg::in_t m;
    m = '0;
    m.a00 = x;
    m.a11 = y;
    m.a22 = z;
    return m;
  endfunction

  function automatic mi3_pkg::elem_t small_elem(int unsigned bits);
    return mi3_pkg::elem_t'($signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // Mix of fully random, well-conditioned, rank-deficient and near-threshold matrices.
  function automatic mi3_pkg::in_t random_matrix();
    mi3_pkg::in_t m;
    int unsigned pick;
    pick = $urandom_range(99);
    m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    if (pick < 35) begin
      m = {small_elem(25), small_elem(25), small_elem(25), small_elem(25), small_elem(25),
           small_elem(25), small_elem(25), small_elem(25), small_elem(25)};
      m.a00 += ONE;
      m.a11 += ONE;
      m.a22 += ONE;
    end else if (pick < 50) begin
      m.a20 = m.a00;
      m.a21 = m.a01;
      m.a22 = m.a02;
      if (pick < 43) m.a22 += mi3_pkg::elem_t'($urandom_range(2));
    end else if (pick < 65) begin
      m = diag(ONE, mi3_pkg::elem_t'($urandom_range(1, 3) << 24),
               mi3_pkg::elem_t'($urandom_range(40)));
      m.a01 = small_elem(20);
    end else if (pick < 80) begin
      m = {small_elem(14), small_elem(14), small_elem(14), small_elem(14), small_elem(14),
           small_elem(14), small_elem(14), small_elem(14), small_elem(14)};
    end
    return m;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(mi3_pkg::in_t m);
    matrix <= m;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    items++;
    @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [mi3_pkg::THR_WIDTH-1:0] v);
    start <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Each cycle the sender idles with the given chance in a hundred.
  task automatic random_phase(int unsigned count, int unsigned idle_pct);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
      issue(random_matrix());
    end
  endtask

  initial begin
    mi3_pkg::in_t m;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity, zero, extremes, scaling, and determinants around the threshold.
    issue(diag(ONE, ONE, ONE));
    issue(diag(-ONE, ONE, -ONE));
    issue('0);
    issue({9{EMAX}});
    issue({9{EMIN}});
    issue(diag(EMAX, EMAX, EMAX));
    issue(diag(EMIN, EMIN, EMIN));
    issue(diag(EMIN, EMAX, EMIN));
    issue(diag(32'sd1, 32'sd1, 32'sd1));
    issue(diag(32'sh00000100, ONE, ONE));
    issue(diag(ONE, ONE, 32'sd16));
    issue(diag(ONE, ONE, 32'sd17));
    issue(diag(ONE, ONE, -32'sd17));
    issue(diag(ONE, ONE, 32'sd18));
    issue(diag(ONE, ONE, 32'sd3));
    m = {ONE, 32'sh02000000, 32'sh03000000, 32'sh04000000, 32'sh05000000, 32'sh06000000,
         32'sh07000000, 32'sh08000000, 32'sh0a000000};
    issue(m);
    m.a22 = 32'sh09000000;
    issue(m);
    issue({ONE, EMAX, EMIN, EMIN, ONE, EMAX, EMAX, EMIN, ONE});
    issue({32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh33333333,
           32'shcccccccc, 32'sh7f00ff00, 32'sh80ff00ff, 32'sh12345678});

    set_threshold('0);
    issue('0);
    issue(diag(32'sd1, 32'sd1, 32'sd1));
    issue(diag(ONE, ONE, 32'sd1));
    random_phase(200, 12);

    set_threshold({mi3_pkg::THR_WIDTH{1'b1}});
    issue(diag(EMAX, EMAX, EMAX));
    issue(diag(ONE, ONE, ONE));
    random_phase(200, 69);

    set_threshold(mi3_pkg::THR_WIDTH'($urandom_range(40)));
    random_phase(120, 0);

    set_threshold(mi3_pkg::THR_WIDTH'(ONE));
    issue(diag(ONE, ONE, ONE));
    issue(diag(ONE, ONE, ONE - 32'sd1));
    random_phase(80, 0);

    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("Checked %0d results from %0d matrices over three pacing phases", results, items);
    $display("and five threshold settings; %0d were flagged singular.", singulars);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_lane.sv
src/mi3_merge.sv
src/matrix_inverse_3x3.sv
src/mi3_checker.sv
tb/inverse_checker.sv
tb/testbench.sv
